// ----- design/tafs_pkg.sv -----
// Shared types, constants and the arctangent step table for triangle_angle_from_sides.
// No dependencies; every other design file imports this package.
package tafs_pkg;

  localparam int VALUE_WIDTH   = 16;
  localparam int MAG_W         = VALUE_WIDTH + 1;
  localparam int NORM_W        = 30;
  localparam int PROD_W        = 2 * NORM_W;
  localparam int SQRT_STEPS    = NORM_W;
  localparam int REM_W         = NORM_W + 3;
  localparam int CORDIC_STEPS  = 20;
  localparam int FRACTION_BITS = 16;
  localparam int ANG_BITS      = 48;
  localparam int XY_W          = NORM_W + 4;
  localparam int Z_W           = ANG_BITS + 10;
  localparam int OUT_W         = 25;
  localparam int ROUND_SH      = ANG_BITS - FRACTION_BITS;
  localparam int SHIFT_W       = 5;

  localparam logic [63:0] DEG_PER_RAD_Q48 = 64'd16127328204063727;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_DOMAIN  = 2'd2,
    ST_DIVZERO = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_OPP   = 2'd0,
    KIND_ADJ   = 2'd1,
    KIND_ANGLE = 2'd2,
    KIND_HYP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_ASIN    = 2'd0,
    OP_ACOS    = 2'd1,
    OP_ATAN    = 2'd2,
    OP_UNKNOWN = 2'd3
  } op_t;

  // How the back end forms the angle before sign and complement.
  typedef enum logic [1:0] {
    MODE_CORDIC = 2'd0,
    MODE_ZERO   = 2'd1,
    MODE_RIGHT  = 2'd2
  } mode_t;

  typedef struct packed {
    status_t           status;
    logic              neg;
    logic              acos;
    mode_t             mode;
    logic              use_sqrt;
    logic [NORM_W-1:0] a;
    logic [NORM_W-1:0] b;
  } item_t;

  // Long division by shift and subtract; it is only evaluated while the step
  // table constants are built, so it never becomes logic.
  function automatic logic [63:0] const_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in degrees with 48 fraction bits, summed from its power series.
  function automatic logic [63:0] atan_q48(input int i);
    logic [63:0] acc;
    logic [63:0] t;
    logic [63:0] dv;
    int          sh;
    logic        done;
    acc  = 64'd0;
    done = 1'b0;
    if (i == 0) begin
      acc = 64'd45 << ANG_BITS;
    end else begin
      for (int n = 0; n < 64; n++) begin
        sh = i * (2 * n + 1);
        if (sh >= 63) done = 1'b1;
        if (!done) begin
          dv = 64'(2 * n + 1);
          t  = const_udiv(DEG_PER_RAD_Q48 >> sh, dv);
          if (n[0] == 1'b1) acc = acc - t;
          else acc = acc + t;
        end
      end
    end
    return acc;
  endfunction

endpackage

// ----- design/tafs_front.sv -----
// Front end: checks the opcode and kinds, takes magnitudes and normalises them.
// Depends on tafs_pkg.
module tafs_front (
  input  logic signed [tafs_pkg::VALUE_WIDTH-1:0] first_value,
  input  logic signed [tafs_pkg::VALUE_WIDTH-1:0] second_value,
  input  logic [1:0]                              first_kind,
  input  logic [1:0]                              second_kind,
  input  logic [1:0]                              opcode,
  output tafs_pkg::item_t                         item
);
  import tafs_pkg::*;

  logic [MAG_W-1:0]   m1, m2, p, q, mx;
  logic signed [VALUE_WIDTH-1:0] opp, adj;
  logic               trig_ok, tan_ok;
  logic [SHIFT_W-1:0] msb, sh;
  logic [NORM_W-1:0]  pw, qw;

  always_comb begin
    m1 = first_value[VALUE_WIDTH-1] ? MAG_W'(-$signed({first_value[VALUE_WIDTH-1], first_value}))
                                   : MAG_W'(first_value);
    m2 = second_value[VALUE_WIDTH-1] ? MAG_W'(-$signed({second_value[VALUE_WIDTH-1], second_value}))
                                    : MAG_W'(second_value);
    trig_ok = (opcode == OP_ASIN && first_kind == KIND_OPP && second_kind == KIND_HYP) ||
              (opcode == OP_ACOS && first_kind == KIND_ADJ && second_kind == KIND_HYP);
    tan_ok  = (opcode == OP_ATAN) &&
              ((first_kind == KIND_OPP && second_kind == KIND_ADJ) ||
               (first_kind == KIND_ADJ && second_kind == KIND_OPP));
    opp = (first_kind == KIND_OPP) ? first_value : second_value;
    adj = (first_kind == KIND_OPP) ? second_value : first_value;

    item.status   = ST_INVALID;
    item.neg      = 1'b0;
    item.acos     = (opcode == OP_ACOS);
    item.mode     = MODE_CORDIC;
    item.use_sqrt = 1'b0;
    p = m2;
    q = m1;
    if (trig_ok) begin
      item.use_sqrt = 1'b1;
      item.neg      = first_value[VALUE_WIDTH-1] ^ second_value[VALUE_WIDTH-1];
      if (second_value == '0) item.status = ST_DIVZERO;
      else if (m1 > m2) item.status = ST_DOMAIN;
      else item.status = ST_OK;
      if (m1 == '0) item.mode = MODE_ZERO;
      else if (m1 == m2) item.mode = MODE_RIGHT;
    end else if (tan_ok) begin
      p = (first_kind == KIND_OPP) ? m2 : m1;
      q = (first_kind == KIND_OPP) ? m1 : m2;
      if (adj == '0) begin
        item.status = (opp == '0) ? ST_DIVZERO : ST_OK;
        item.mode   = MODE_RIGHT;
        item.neg    = opp[VALUE_WIDTH-1];
      end else begin
        item.status = ST_OK;
        item.neg    = opp[VALUE_WIDTH-1] ^ adj[VALUE_WIDTH-1];
        if (opp == '0) item.mode = MODE_ZERO;
      end
    end

    // Shift both magnitudes so that the larger lands in [2^29, 2^30).
    mx  = (p > q) ? p : q;
    msb = '0;
    for (int k = 0; k < MAG_W; k++) begin
      if (mx[k]) msb = SHIFT_W'(k);
    end
    sh = SHIFT_W'(NORM_W - 1) - msb;
    pw = NORM_W'(p) << sh;
    qw = NORM_W'(q) << sh;
    item.a = pw;
    item.b = qw;
  end

endmodule

// ----- design/tafs_queue.sv -----
// Two-entry queue between the front end and the arithmetic back end.
// Depends on tafs_pkg.
module tafs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  tafs_pkg::item_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output logic            not_empty,
  output tafs_pkg::item_t rd_data
);
  import tafs_pkg::*;

  item_t       mem [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

// ----- design/tafs_back.sv -----
// Back end: multiplier, pipelined square root, CORDIC vectoring stages and rounding.
// Depends on tafs_pkg.
module tafs_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  tafs_pkg::item_t       in_item,
  output logic                  in_take,
  output logic                  out_valid,
  input  logic                  out_take,
  output logic signed [tafs_pkg::OUT_W-1:0] angle,
  output logic [1:0]            out_status
);
  import tafs_pkg::*;

  localparam logic signed [Z_W-1:0] RIGHT_Z = Z_W'(90) <<< ANG_BITS;

  logic en;
  assign en      = !out_valid || out_take;
  assign in_take = en && in_valid;

  // Square root pipeline, index 0 is the multiplier output.
  logic              sv   [SQRT_STEPS+1];
  item_t             sit  [SQRT_STEPS+1];
  logic [PROD_W-1:0] sd   [SQRT_STEPS+1];
  logic [REM_W-1:0]  srem [SQRT_STEPS+1];
  logic [NORM_W-1:0] sroot[SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (en) sv[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sit[0]   <= in_item;
      sd[0]    <= PROD_W'(({1'b0, in_item.a} - {1'b0, in_item.b}) *
                          ({1'b0, in_item.a} + {1'b0, in_item.b}));
      srem[0]  <= '0;
      sroot[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [REM_W-1:0] pre, trial;
    assign pre   = {srem[k][REM_W-3:0], sd[k][PROD_W-1 -: 2]};
    assign trial = REM_W'({sroot[k], 2'b01});
    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else if (en) sv[k+1] <= sv[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sit[k+1] <= sit[k];
        sd[k+1]  <= sd[k] << 2;
        if (pre >= trial) begin
          srem[k+1]  <= pre - trial;
          sroot[k+1] <= {sroot[k][NORM_W-2:0], 1'b1};
        end else begin
          srem[k+1]  <= pre;
          sroot[k+1] <= {sroot[k][NORM_W-2:0], 1'b0};
        end
      end
    end
  end

  // CORDIC vectoring, index 0 is the entry point fed from the root stage.
  logic                   cv [CORDIC_STEPS+1];
  item_t                  cit[CORDIC_STEPS+1];
  logic signed [XY_W-1:0] cx [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] cy [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  cz [CORDIC_STEPS+1];

  assign cv[0]  = sv[SQRT_STEPS];
  assign cit[0] = sit[SQRT_STEPS];
  assign cx[0]  = sit[SQRT_STEPS].use_sqrt ? XY_W'(sroot[SQRT_STEPS])
                                           : XY_W'(sit[SQRT_STEPS].a);
  assign cy[0]  = XY_W'(sit[SQRT_STEPS].b);
  assign cz[0]  = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [Z_W-1:0] ATAN_I = Z_W'(atan_q48(i));
    logic signed [XY_W-1:0] xs, ys;
    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else if (en) cv[i+1] <= cv[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cit[i+1] <= cit[i];
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + ATAN_I;
        end else begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - ATAN_I;
        end
      end
    end
  end

  // Special angles, sign, complement for arccosine and rounding.
  item_t                 fit;
  logic signed [Z_W-1:0] z0, z1, z2, zr;
  always_comb begin
    fit = cit[CORDIC_STEPS];
    unique case (fit.mode)
      MODE_ZERO:  z0 = '0;
      MODE_RIGHT: z0 = RIGHT_Z;
      default:    z0 = cz[CORDIC_STEPS];
    endcase
    z1 = fit.neg ? -z0 : z0;
    z2 = fit.acos ? RIGHT_Z - z1 : z1;
    zr = z2 + (Z_W'(1) <<< (ROUND_SH - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= cv[CORDIC_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_status <= fit.status;
      angle      <= (fit.status == ST_OK) ? zr[ROUND_SH +: OUT_W] : '0;
    end
  end

endmodule

// ----- design/triangle_angle_from_sides.sv -----
// A request passes the queue, multiplier, root stages, CORDIC stages and output register.
// Throughput: one request per cycle while results are popped; the stages are fully pipelined.
// The pipeline advances whenever its output register is empty or being popped.
// Reset (rst, synchronous, active high) empties the queue and all stage valid flags.
// Depends on tafs_pkg, tafs_front, tafs_queue and tafs_back.
module triangle_angle_from_sides (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    push,
  output logic                                    full,
  input  logic signed [tafs_pkg::VALUE_WIDTH-1:0] first_value,
  input  logic signed [tafs_pkg::VALUE_WIDTH-1:0] second_value,
  input  logic [1:0]                              first_kind,
  input  logic [1:0]                              second_kind,
  input  logic [1:0]                              opcode,
  output logic                                    empty,
  input  logic                                    pop,
  output logic signed [tafs_pkg::OUT_W-1:0]       angle_degrees,
  output logic [1:0]                              status
);
  import tafs_pkg::*;

  // The front end classifies each request combinationally: it checks the kind
  // codes against the opcode, raises the status for invalid, out-of-domain and
  // divide-by-zero cases, and normalises the two magnitudes together.
  item_t front_item;
  item_t q_item;
  logic  q_not_empty, q_take, out_valid, push_ok;

  tafs_front u_front (
    .first_value (first_value),
    .second_value(second_value),
    .first_kind  (first_kind),
    .second_kind (second_kind),
    .opcode      (opcode),
    .item        (front_item)
  );

  // A short queue decouples request acceptance from the stalls of the back end.
  assign push_ok = push && !full;

  tafs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push_ok),
    .wr_data  (front_item),
    .full     (full),
    .rd_en    (q_take),
    .not_empty(q_not_empty),
    .rd_data  (q_item)
  );

  // The back end holds the multiplier, the root stages and the CORDIC stages;
  // its final register is the result seen on the output ports.
  tafs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_not_empty),
    .in_item   (q_item),
    .in_take   (q_take),
    .out_valid (out_valid),
    .out_take  (pop),
    .angle     (angle_degrees),
    .out_status(status)
  );

  assign empty = !out_valid;

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |-> (angle_degrees == '0))
    else $error("non-ok result carries a non-zero angle");

  a_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ($signed(angle_degrees) <= 25'sd11796480 &&
                $signed(angle_degrees) >= -25'sd11796480))
    else $error("angle beyond one hundred and eighty degrees");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for triangle_angle_from_sides: directed, random and back-pressure
// requests are checked against an in-bench model of the inverse trig CORDIC datapath.
// Depends on tafs_pkg and the triangle_angle_from_sides design files.
module testbench;
  import tafs_pkg::*;

  // One expected result, as the block should present it on its result ports.
  typedef struct {
    logic signed [OUT_W-1:0] angle;
    status_t                 st;
  } angle_result_t;

  logic                          clk;
  logic                          rst;
  logic                          push;
  logic                          full;
  logic signed [VALUE_WIDTH-1:0] first_value;
  logic signed [VALUE_WIDTH-1:0] second_value;
  logic [1:0]                    first_kind;
  logic [1:0]                    second_kind;
  logic [1:0]                    opcode;
  logic                          empty;
  logic                          pop;
  logic signed [OUT_W-1:0]       angle_degrees;
  logic [1:0]                    status;

  // Results still owed by the block, oldest first.
  angle_result_t pending_angles[$];
  longint        atan_table[CORDIC_STEPS];
  int            mismatch_count;
  int            quiet_cycles;
  bit            hold_pop;
  bit            steady;

  triangle_angle_from_sides dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .first_value(first_value), .second_value(second_value),
    .first_kind(first_kind), .second_kind(second_kind), .opcode(opcode),
    .empty(empty), .pop(pop), .angle_degrees(angle_degrees), .status(status)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // The arctangent step table is built here from the power series of atan(2^-i),
  // in degrees with 48 fraction bits, so that the model rounds exactly as the block does.
  initial begin
    bit [63:0] acc;
    bit [63:0] term;
    int        sh;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      acc = 64'd0;
      if (i == 0) begin
        acc = 64'd45 << ANG_BITS;
      end else begin
        for (int n = 0; n < 64; n++) begin
          sh = i * (2 * n + 1);
          if (sh >= 63) break;
          term = (DEG_PER_RAD_Q48 >> sh) / 64'(2 * n + 1);
          if (n % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
      end
      atan_table[i] = longint'(acc);
    end
  end

  // Scales both magnitudes together until the larger one lies in [2^29, 2^30).
  // Scaling down truncates; the hardware shifter only ever shifts left.
  function automatic void scale_pair(inout bit [63:0] p, inout bit [63:0] q);
    bit [63:0] m;
    m = (p > q) ? p : q;
    if (m != 0) begin
      while (m < (64'd1 << 29)) begin
        m = m << 1; p = p << 1; q = q << 1;
      end
      while (m >= (64'd1 << 30)) begin
        m = m >> 1; p = p >> 1; q = q >> 1;
      end
    end
  endfunction

  // Vectoring CORDIC: drives y towards zero and accumulates the angle turned.
  function automatic longint cordic_angle(longint x, longint y);
    longint z;
    longint xs;
    longint ys;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + atan_table[i];
      end else begin
        x = x - ys; y = y + xs; z = z - atan_table[i];
      end
    end
    return z;
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] d);
    bit [63:0] res;
    bit [63:0] bitpos;
    res = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > d) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (d >= res + bitpos) begin
        d = d - (res + bitpos);
        res = (res >> 1) + bitpos;
      end else begin
        res = res >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return res;
  endfunction

  // Works out the angle and status that one request must produce.
  function automatic angle_result_t predict_angle(logic signed [VALUE_WIDTH-1:0] v1,
                                                  logic signed [VALUE_WIDTH-1:0] v2,
                                                  kind_t k1, kind_t k2, op_t op);
    angle_result_t r;
    longint        a1;
    longint        a2;
    longint        opp;
    longint        adj;
    longint        z;
    longint        rounded;
    longint        right_angle;
    bit [63:0]     hm;
    bit [63:0]     sm;
    bit [63:0]     c;
    bit            neg;
    a1 = longint'(v1);
    a2 = longint'(v2);
    z = 0;
    right_angle = longint'(90) <<< ANG_BITS;
    r.st = ST_INVALID;
    r.angle = '0;
    if ((op == OP_ASIN && k1 == KIND_OPP && k2 == KIND_HYP) ||
        (op == OP_ACOS && k1 == KIND_ADJ && k2 == KIND_HYP)) begin
      if (a2 == 0) begin
        r.st = ST_DIVZERO;
      end else begin
        hm = (a2 < 0) ? -a2 : a2;
        sm = (a1 < 0) ? -a1 : a1;
        neg = (a1 < 0) != (a2 < 0);
        if (sm > hm) begin
          r.st = ST_DOMAIN;
        end else begin
          r.st = ST_OK;
          if (sm == 0) begin
            z = 0;
          end else if (sm == hm) begin
            z = right_angle;
          end else begin
            scale_pair(hm, sm);
            c = int_sqrt((hm - sm) * (hm + sm));
            z = cordic_angle(longint'(c), longint'(sm));
          end
          if (neg) z = -z;
          // Arccosine is the complement of arcsine, taken before rounding.
          if (op == OP_ACOS) z = right_angle - z;
        end
      end
    end else if (op == OP_ATAN && ((k1 == KIND_OPP && k2 == KIND_ADJ) ||
                                   (k1 == KIND_ADJ && k2 == KIND_OPP))) begin
      opp = (k1 == KIND_OPP) ? a1 : a2;
      adj = (k1 == KIND_OPP) ? a2 : a1;
      if (adj == 0) begin
        if (opp == 0) begin
          r.st = ST_DIVZERO;
        end else begin
          r.st = ST_OK;
          z = (opp < 0) ? -right_angle : right_angle;
        end
      end else begin
        hm = (adj < 0) ? -adj : adj;
        sm = (opp < 0) ? -opp : opp;
        neg = (opp < 0) != (adj < 0);
        r.st = ST_OK;
        if (sm != 0) begin
          scale_pair(hm, sm);
          z = cordic_angle(longint'(hm), longint'(sm));
          if (neg) z = -z;
        end
      end
    end
    if (r.st == ST_OK) begin
      rounded = (z + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
      r.angle = rounded[OUT_W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Presents one request from the next falling edge and holds it until the block takes it.
  // The expected result is queued at the accepting edge, so ordering matches the block.
  task automatic send_request(input logic signed [VALUE_WIDTH-1:0] v1,
                              input logic signed [VALUE_WIDTH-1:0] v2,
                              input kind_t k1, input kind_t k2, input op_t op);
    bit taken;
    @(negedge clk);
    push = 1'b1;
    first_value = v1;
    second_value = v2;
    first_kind = k1;
    second_kind = k2;
    opcode = op;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      if (!full) begin
        taken = 1'b1;
        pending_angles.push_back(predict_angle(v1, v2, k1, k2, op));
      end
    end
  endtask

  // Drops push for a short random burst now and then, unless the run is in its steady part.
  task automatic sender_gap();
    int gap;
    if (!steady && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      push = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // A side length of random magnitude: the width is drawn first so that small and
  // large values turn up alike, and the extremes are picked on purpose now and then.
  function automatic logic signed [VALUE_WIDTH-1:0] random_side();
    logic signed [VALUE_WIDTH-1:0] r;
    int                            w;
    case ($urandom_range(0, 9))
      0: r = 16'sh7fff;
      1: r = 16'sh8000;
      2: r = '0;
      default: begin
        r = VALUE_WIDTH'($urandom);
        w = $urandom_range(1, VALUE_WIDTH);
        r = r >>> (VALUE_WIDTH - w);
      end
    endcase
    return r;
  endfunction

  function automatic longint magnitude(logic signed [VALUE_WIDTH-1:0] v);
    return (v < 0) ? -longint'(v) : longint'(v);
  endfunction

  // Mostly well-formed requests with random content; roughly one in eight is noise
  // with arbitrary kinds and opcode, including the unknown function.
  task automatic send_random_request();
    logic signed [VALUE_WIDTH-1:0] v1;
    logic signed [VALUE_WIDTH-1:0] v2;
    logic signed [VALUE_WIDTH-1:0] t;
    v1 = random_side();
    v2 = random_side();
    case ($urandom_range(0, 7))
      0, 1: begin
        // Keep the ratio within one most of the time so the CORDIC path is exercised.
        if (magnitude(v1) > magnitude(v2) && $urandom_range(0, 4) != 0) begin
          t = v1; v1 = v2; v2 = t;
        end
        send_request(v1, v2, KIND_OPP, KIND_HYP, OP_ASIN);
      end
      2, 3: begin
        if (magnitude(v1) > magnitude(v2) && $urandom_range(0, 4) != 0) begin
          t = v1; v1 = v2; v2 = t;
        end
        send_request(v1, v2, KIND_ADJ, KIND_HYP, OP_ACOS);
      end
      4, 5: send_request(v1, v2, KIND_OPP, KIND_ADJ, OP_ATAN);
      6: send_request(v1, v2, KIND_ADJ, KIND_OPP, OP_ATAN);
      default: send_request(v1, v2, kind_t'($urandom_range(0, 3)),
                            kind_t'($urandom_range(0, 3)), op_t'($urandom_range(0, 3)));
    endcase
  endtask

  // Directed requests: every function, the invalid combinations, the zero divisor,
  // a ratio above one, a side equal to the hypotenuse, zero sides and the field extremes.
  task automatic test_directed();
    send_request(16'sd3, 16'sd5, KIND_OPP, KIND_HYP, OP_ASIN);
    send_request(-16'sd1, 16'sd2, KIND_OPP, KIND_HYP, OP_ASIN);
    send_request(16'sd4, 16'sd5, KIND_ADJ, KIND_HYP, OP_ACOS);
    send_request(16'sd3, 16'sd4, KIND_OPP, KIND_ADJ, OP_ATAN);
    send_request(16'sd4, -16'sd3, KIND_ADJ, KIND_OPP, OP_ATAN);
    send_request(16'sd3, 16'sd5, KIND_OPP, KIND_HYP, OP_UNKNOWN);
    send_request(16'sd3, 16'sd5, KIND_ANGLE, KIND_HYP, OP_ASIN);
    send_request(16'sd3, 16'sd5, KIND_OPP, KIND_HYP, OP_ACOS);
    send_request(16'sd3, 16'sd5, KIND_HYP, KIND_ANGLE, OP_ATAN);
    send_request(16'sd7, 16'sd0, KIND_OPP, KIND_HYP, OP_ASIN);
    send_request(16'sd6, 16'sd5, KIND_OPP, KIND_HYP, OP_ASIN);
    send_request(-16'sd6, 16'sd5, KIND_ADJ, KIND_HYP, OP_ACOS);
    send_request(16'sh8000, 16'sh8000, KIND_OPP, KIND_HYP, OP_ASIN);
    send_request(16'sh7fff, 16'sh8000, KIND_OPP, KIND_HYP, OP_ASIN);
    send_request(-16'sd9, 16'sd9, KIND_ADJ, KIND_HYP, OP_ACOS);
    send_request(16'sd9, 16'sd9, KIND_ADJ, KIND_HYP, OP_ACOS);
    send_request(16'sd0, 16'sh7fff, KIND_OPP, KIND_HYP, OP_ASIN);
    send_request(16'sd0, -16'sd4, KIND_ADJ, KIND_HYP, OP_ACOS);
    send_request(-16'sd5, 16'sd0, KIND_OPP, KIND_ADJ, OP_ATAN);
    send_request(16'sd0, 16'sd12, KIND_ADJ, KIND_OPP, OP_ATAN);
    send_request(16'sd0, 16'sd0, KIND_OPP, KIND_ADJ, OP_ATAN);
    send_request(16'sd0, 16'sh8000, KIND_OPP, KIND_ADJ, OP_ATAN);
    send_request(16'sh7fff, 16'sd1, KIND_OPP, KIND_ADJ, OP_ATAN);
    send_request(16'sd1, 16'sh8000, KIND_OPP, KIND_ADJ, OP_ATAN);
    send_request(16'sh7fff, 16'sh7fff, KIND_ADJ, KIND_OPP, OP_ATAN);
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_random_request();
      sender_gap();
    end
  endtask

  // The receiver stops popping for a long stretch while requests keep coming,
  // so the pipeline and the queue in front of it fill up and full stalls the sender.
  task automatic test_backpressure();
    hold_pop = 1'b1;
    for (int n = 0; n < 150; n++) send_random_request();
  endtask

  // A run of back-to-back requests with pop held high, at the full rate of the block.
  task automatic test_streaming();
    steady = 1'b1;
    test_random(200);
  endtask

  // Receiver: pops with random bursts of stall, and stops altogether while hold_pop is set.
  initial begin
    int stall;
    int held;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_pop) begin
        pop = 1'b0;
        held = 0;
        while (held < 300) begin
          @(negedge clk);
          held++;
        end
        hold_pop = 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 3);
        pop = 1'b0;
        repeat (stall) @(negedge clk);
      end else begin
        pop = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Checker: every result taken by the receiver is compared with the oldest expectation.
  always @(posedge clk) begin
    angle_result_t want;
    if (!rst && pop && !empty) begin
      if (pending_angles.size() == 0) begin
        report_mismatch("unexpected result, angle", longint'(angle_degrees), 0);
      end else begin
        want = pending_angles.pop_front();
        if (angle_degrees !== want.angle)
          report_mismatch("angle_degrees", longint'(angle_degrees), longint'(want.angle));
        if (status !== want.st)
          report_mismatch("status", longint'(status), longint'(want.st));
      end
    end
  end

  // Watchdog: the run is hung if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 5000) begin
      $display("** triangle_angle_from_sides: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int drain;
    rst = 1'b1;
    push = 1'b0;
    first_value = '0;
    second_value = '0;
    first_kind = KIND_OPP;
    second_kind = KIND_OPP;
    opcode = OP_ASIN;
    mismatch_count = 0;
    hold_pop = 1'b0;
    steady = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(550);
    test_backpressure();
    test_random(400);
    test_streaming();

    @(negedge clk);
    push = 1'b0;
    // Let the pipeline drain, then allow its latency again for any stray result.
    drain = 0;
    while (pending_angles.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pending_angles.size() == 0) begin
      $display("** triangle_angle_from_sides: PASSED **");
    end else begin
      $display("** triangle_angle_from_sides: FAILED **");
    end
    $finish;
  end

endmodule
